/* rtl/fqs_pkg.sv */
// Package for the queue with search: sizes, operation and status codes,
// and the command record that travels from the front end to the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fqs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SRCH = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [DATA_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic pop;
  } cmd_ctrl_t;

endpackage : fqs_pkg
`default_nettype wire

/* rtl/fqs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module fqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule : fqs_ram
`default_nettype wire

/* rtl/fqs_front.sv */
// Front end: accepts input transactions, decodes the operation and holds
// the commands in a short queue for the back end. Depends on fqs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fqs_front
  import fqs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [OP_W-1:0]          operation_i,
  input  wire logic signed [DATA_W-1:0] data_in_i,
  output cmd_t                          cmd_o,
  input  wire cmd_ctrl_t                ctrl_i,
  output logic                          cmd_valid_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_new;

  always_comb begin
    cmd_new.data = data_in_i;
    case (operation_i)
      OP_ENQ:  cmd_new.kind = CMD_ENQ;
      OP_DEQ:  cmd_new.kind = CMD_DEQ;
      OP_SRCH: cmd_new.kind = CMD_SRCH;
      default: cmd_new.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = ctrl_i.pop && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule : fqs_front
`default_nettype wire

/* rtl/fqs_back.sv */
// Back end: executes queue commands against the ring buffer and drives the
// registered result port. Depends on fqs_pkg and fqs_ram.
`timescale 1ns / 1ps
`default_nettype none
module fqs_back
  import fqs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire logic                cmd_valid_i,
  output cmd_ctrl_t                ctrl_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [POS_W-1:0]         position_o,
  output logic [OCC_W-1:0]         entry_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [DATA_W-1:0]  key_q, key_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [OCC_W-1:0]   count_q, count_d;

  logic               out_free;
  logic               load;
  logic               pop;
  logic               wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_data;
  logic [IDX_W-1:0]   head_nxt;
  logic [IDX_W-1:0]   tail_nxt;
  logic [IDX_W-1:0]   idx_nxt;
  logic               hit;
  logic               last;

  fqs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (cmd_i.data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign head_nxt = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign idx_nxt  = (idx_q == IDX_W'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign hit      = (rd_data == key_q);
  assign last     = ({1'b0, k_q} == CNT_W'(occ_q - 1'b1));

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    k_d      = k_q;
    key_d    = key_q;
    pop      = 1'b0;
    load     = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    status_d = ST_OK;
    data_d   = '0;
    pos_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop = 1'b1;
          case (cmd_i.kind)
            CMD_ENQ: begin
              load = 1'b1;
              if (occ_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_en  = 1'b1;
                tail_d = tail_nxt;
                occ_d  = occ_q + 1'b1;
              end
            end
            CMD_DEQ: begin
              if (occ_q == '0) begin
                load     = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_DEQ;
              end
            end
            CMD_SRCH: begin
              if (occ_q == '0) begin
                load     = 1'b1;
                status_d = ST_NOTFOUND;
              end else begin
                rd_en   = 1'b1;
                key_d   = cmd_i.data;
                k_d     = '0;
                idx_d   = head_q;
                state_d = S_SRCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        if (out_free) begin
          load    = 1'b1;
          data_d  = rd_data;
          head_d  = head_nxt;
          occ_d   = occ_q - 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SRCH: begin
        if (hit) begin
          if (out_free) begin
            load    = 1'b1;
            data_d  = key_q;
            pos_d   = POS_W'(k_q);
            state_d = S_IDLE;
          end
        end else if (last) begin
          if (out_free) begin
            load     = 1'b1;
            status_d = ST_NOTFOUND;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_nxt;
          idx_d   = idx_nxt;
          k_d     = k_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    count_d     = OCC_W'(occ_d);
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  assign ctrl_o.pop    = pop;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_out_o    = data_q;
  assign position_o    = pos_q;
  assign entry_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    k_q   <= k_d;
    key_q <= key_d;
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
    end
  end

endmodule : fqs_back
`default_nettype wire

/* rtl/fifo_queue_with_search_top.sv */
// Top level of the queue with search: joins the front end and the back end.
// Depends on fqs_pkg, fqs_front and fqs_back.
//
// A bounded FIFO of 16 signed 32-bit entries held in a ring buffer RAM. Each
// input transaction is an enqueue, a dequeue or a search and gives exactly
// one result transaction carrying a status and the entry count after the
// operation. Commands pass through a two-entry queue into the back end,
// which runs one command at a time. In the back end an enqueue, a rejected
// operation or an unused code completes straight from the idle state; a
// dequeue first reads the entry RAM and then gives its result; a search
// reads the single read port of the entry RAM once per cycle from head
// toward tail until it finds the key or reaches the tail. While a result
// waits on a stalled output, the back end holds its next command, and the
// command queue then fills and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module fifo_queue_with_search_top
  import fqs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [OP_W-1:0]          operation_i,
  input  wire logic signed [DATA_W-1:0] data_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ST_W-1:0]               status_o,
  output logic signed [DATA_W-1:0]      data_out_o,
  output logic [POS_W-1:0]              position_o,
  output logic [OCC_W-1:0]              entry_count_o
);

  cmd_t      cmd;
  cmd_ctrl_t ctrl;
  logic      cmd_valid;

  fqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_in_i   (data_in_i),
    .cmd_o       (cmd),
    .ctrl_i      (ctrl),
    .cmd_valid_o (cmd_valid)
  );

  fqs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .ctrl_o        (ctrl),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

endmodule : fifo_queue_with_search_top
`default_nettype wire

/* dv/fifo_queue_with_search_top_tb.sv */
// Self-checking testbench for fifo_queue_with_search_top: directed and random
// enqueue, dequeue and search traffic with a ring buffer predictor in the bench.
// Depends on fqs_pkg and the RTL of fifo_queue_with_search_top.
`timescale 1ns / 1ps
module fifo_queue_with_search_top_tb;
  import fqs_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = CMD_NOP;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned END_PAUSE = 40;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] data;
  } queue_op_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         pos;
    logic [OCC_W-1:0]         count;
  } queue_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          operation_i = '0;
  logic signed [DATA_W-1:0] data_in_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [POS_W-1:0]         position_o;
  logic [OCC_W-1:0]         entry_count_o;

  queue_op_t                op_backlog[$];
  queue_result_t            awaited_results[$];
  logic signed [DATA_W-1:0] gen_contents[$];
  int unsigned              sender_idle_pct = 0;
  int unsigned              receiver_stall_pct = 0;
  int unsigned              error_count = 0;
  int unsigned              cycle_count = 0;

  logic signed [DATA_W-1:0] ring_words[DEPTH];
  logic [IDX_W-1:0]         ring_head = '0;
  logic [IDX_W-1:0]         ring_tail = '0;
  int unsigned              ring_fill = 0;

  fifo_queue_with_search_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .data_in_i     (data_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Applies one operation to the bench copy of the ring buffer and returns
  // the result the block must report for it.
  function automatic queue_result_t run_queue_op(input queue_op_t op_in);
    queue_result_t    res;
    logic [IDX_W-1:0] idx;
    bit               hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    case (op_in.op)
      OP_ENQ: begin
        if (ring_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_words[ring_tail] = op_in.data;
          ring_tail = ring_next(ring_tail);
          ring_fill++;
        end
      end
      OP_DEQ: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring_words[ring_head];
          ring_head = ring_next(ring_head);
          ring_fill--;
        end
      end
      OP_SRCH: begin
        idx = ring_head;
        for (int k = 0; k < ring_fill; k++) begin
          if (!hit && ring_words[idx] == op_in.data) begin
            hit = 1'b1;
            res.pos = POS_W'(k);
          end
          idx = ring_next(idx);
        end
        if (hit) begin
          res.data = op_in.data;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    res.count = OCC_W'(ring_fill);
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    if (error_count < 10) begin
      $display("%s", msg);
    end
    error_count++;
  endtask

  // Queues one operation for the driver and tracks the contents it will
  // produce so that random searches can aim at stored values.
  task automatic add_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    op_backlog.push_back('{op: op, data: val});
    if (op == OP_ENQ && gen_contents.size() < DEPTH) begin
      gen_contents.push_back(val);
    end else if (op == OP_DEQ && gen_contents.size() > 0) begin
      void'(gen_contents.pop_front());
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      return 32'sh8000_0000;
    end else if (r < 6) begin
      return 32'sh7FFF_FFFF;
    end else if (r < 10) begin
      return -32'sd1;
    end else if (r < 40) begin
      return DATA_W'($urandom_range(7));
    end
    return $urandom;
  endfunction

  task automatic add_random_ops(input int unsigned n);
    int unsigned enq_pct;
    int unsigned r;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      r = $urandom_range(99);
      if (r < 3) begin
        add_op(OP_NONE, $urandom);
      end else if (r < 28) begin
        if (gen_contents.size() > 0 && $urandom_range(99) < 70) begin
          add_op(OP_SRCH, gen_contents[$urandom_range(gen_contents.size() - 1)]);
        end else begin
          add_op(OP_SRCH, pick_value());
        end
      end else if ($urandom_range(99) < enq_pct) begin
        add_op(OP_ENQ, pick_value());
      end else begin
        add_op(OP_DEQ, pick_value());
      end
    end
  endtask

  task automatic add_directed_ops();
    add_op(OP_DEQ, 32'sd0);
    add_op(OP_SRCH, 32'sd0);
    add_op(OP_NONE, 32'sh7FFF_FFFF);
    add_op(OP_ENQ, 32'sh7FFF_FFFF);
    add_op(OP_ENQ, 32'sh8000_0000);
    add_op(OP_SRCH, 32'sh8000_0000);
    add_op(OP_SRCH, 32'sd5);
    add_op(OP_ENQ, 32'sd0);
    add_op(OP_ENQ, -32'sd1);
    for (int i = 0; i < 12; i++) begin
      add_op(OP_ENQ, 32'sh5A5A_0000 + i);
    end
    add_op(OP_ENQ, 32'sh1234_5678);
    add_op(OP_SRCH, 32'sh5A5A_000B);
    add_op(OP_SRCH, 32'sh7FFF_FFFF);
    add_op(OP_NONE, 32'sd0);
    add_op(OP_DEQ, 32'sd0);
  endtask

  task automatic wait_until_drained();
    while (op_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_directed_ops();
    add_random_ops(175);
    wait_until_drained();
    sender_idle_pct = 71;
    receiver_stall_pct = 0;
    add_random_ops(200);
    wait_until_drained();
    sender_idle_pct = 0;
    receiver_stall_pct = 71;
    add_random_ops(200);
    wait_until_drained();
    sender_idle_pct = 33;
    receiver_stall_pct = 33;
    add_random_ops(200);
    wait_until_drained();
    repeat (END_PAUSE) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("fifo_queue_with_search_top_tb: done, clean");
    end else begin
      $display("fifo_queue_with_search_top_tb: done, errors");
    end
    $finish;
  end

  // A transaction is taken when valid is high and stall is low at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= '0;
      data_in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(run_queue_op('{op: operation_i, data: data_in_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          operation_i <= op_backlog[0].op;
          data_in_i <= op_backlog[0].data;
          void'(op_backlog.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result: status %0d data %0d pos %0d count %0d",
                                 status_o, data_out_o, position_o, entry_count_o));
        end else begin
          exp_res = awaited_results.pop_front();
          if (status_o !== exp_res.status || data_out_o !== exp_res.data ||
              position_o !== exp_res.pos || entry_count_o !== exp_res.count) begin
            log_mismatch($sformatf(
              "mismatch: expected status %0d data %0d pos %0d count %0d, got %0d %0d %0d %0d",
              exp_res.status, exp_res.data, exp_res.pos, exp_res.count,
              status_o, data_out_o, position_o, entry_count_o));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fifo_queue_with_search_top_tb: done, errors");
      $finish;
    end
  end

endmodule

/* fifo_queue_with_search_top.f */
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fqs_front.sv
rtl/fqs_back.sv
rtl/fifo_queue_with_search_top.sv
dv/fifo_queue_with_search_top_tb.sv
